// ----- hw/rtl/rbfe_pkg.sv -----
// Shared types and constants of the ring buffer frame extractor.
// Holds the word formats, the settings record, register indexes and controller states.
// No dependencies.
`timescale 1ns / 1ps

package rbfe_pkg;

   localparam int RING_DEPTH_DEFAULT = 256;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_MARKER     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_CODES  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUSY_THRESHOLD = 2'd3;

   localparam logic [7:0] BUSY_THRESHOLD_RESET = 8'd20;

   localparam int CODE_DB      = 0;
   localparam int CODE_DB_FAST = 1;
   localparam int CODE_RX_DB   = 2;
   localparam int CODE_SERIAL  = 3;
   localparam int CODE_COUNTER = 4;
   localparam int CODE_MONITOR = 5;

   localparam logic [7:0] LEN_RX_DB   = 8'd12;
   localparam logic [7:0] LEN_SERIAL  = 8'd19;
   localparam logic [7:0] LEN_COUNTER = 8'd9;
   localparam logic [7:0] LEN_MONITOR = 8'd8;
   localparam logic [7:0] LEN_OTHER   = 8'd7;
   localparam logic [7:0] LEN_DB_BASE = 8'd8;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_POLL  = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       ready_res;
      logic       frame_ok;
      logic [7:0] frame_start;
      logic [7:0] frame_length;
      logic [7:0] frame_command;
      logic [7:0] arg_count;
      logic [7:0] monitor_param;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic [23:0] start_marker;
      logic [23:0] end_marker;
      logic [47:0] command_codes;
      logic [7:0]  busy_threshold;
   } cfg_type;

   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_addr;
      logic [7:0] wr_data;
      logic       rd_en;
      logic [7:0] rd_addr;
   } mem_cmd_type;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_STORE    = 12'b0000_0000_0010,
      ST_POLL     = 12'b0000_0000_0100,
      ST_SKIP_RD  = 12'b0000_0000_1000,
      ST_SKIP_CHK = 12'b0000_0001_0000,
      ST_HDR_RD   = 12'b0000_0010_0000,
      ST_HDR_CHK  = 12'b0000_0100_0000,
      ST_LEN      = 12'b0000_1000_0000,
      ST_END_SET  = 12'b0001_0000_0000,
      ST_END_RD   = 12'b0010_0000_0000,
      ST_END_CHK  = 12'b0100_0000_0000,
      ST_FINISH   = 12'b1000_0000_0000
   } state_type;

   function automatic logic [7:0] code_byte(logic [47:0] codes, int k);
      return codes[8*k +: 8];
   endfunction

endpackage

// ----- hw/rtl/ring_buffer_frame_extractor_core.sv -----
// Top level of the ring buffer frame extractor: settings registers, ring and sequencer.
// Depends on rbfe_pkg, rbfe_ring and rbfe_ctrl.
//
// Each request word either stores one received byte into the ring (cmd 0) or polls the
// frame search (cmd 1); every request yields exactly one response word. A poll updates
// the ready flag, skips to the first start byte, checks the start markers, derives the
// frame length from the command and count bytes and checks the end markers. A good
// frame is reported and consumed; a bad one advances the read index by one.
// One request is worked on at a time, and req_stall is high while it is in progress.
// A store goes through the store and finish states before its response is loaded. A
// poll reads the ring one byte at a time through its single read port: it tests for an
// empty ring and reads the first byte, then reads and checks each skipped byte, reads
// the header, derives the frame length, reads the end markers and loads the response.
// The sequencer then returns to idle, where the next request is taken.
// The response sits in an output register; a new request is accepted while it waits,
// and a stalled receiver only holds the sequencer once the next response is ready.
// Settings must be written through the csr port while idle; the block does not enforce it.
// Synchronous reset empties the ring, sets ready and loads the default settings; the
// ring contents themselves are not cleared.
`timescale 1ns / 1ps

module ring_buffer_frame_extractor_core #(
   parameter int RING_DEPTH = rbfe_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rbfe_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rbfe_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [rbfe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rbfe_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rbfe_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   mem_cmd_type mem_cmd;
   logic [7:0]  mem_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_MARKER:   cfg_in.start_marker   = csr_wdata[23:0];
            CSR_END_MARKER:     cfg_in.end_marker     = csr_wdata[23:0];
            CSR_COMMAND_CODES:  cfg_in.command_codes  = csr_wdata[47:0];
            CSR_BUSY_THRESHOLD: cfg_in.busy_threshold = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker   <= '0;
         cfg_ff.end_marker     <= '0;
         cfg_ff.command_codes  <= '0;
         cfg_ff.busy_threshold <= BUSY_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbfe_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (mem_rdata)
   );

   rbfe_ctrl #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cfg       (cfg_ff),
      .mem_cmd   (mem_cmd),
      .mem_rdata (mem_rdata)
   );

endmodule

// ----- hw/rtl/rbfe_ring.sv -----
// Receive ring storage: one write port and one read port with registered read data.
// Depends on rbfe_pkg for the access command format.
`timescale 1ns / 1ps

module rbfe_ring #(
   parameter int RING_DEPTH = rbfe_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  rbfe_pkg::mem_cmd_type mem_cmd,
   output logic [7:0]            rd_data
);
   import rbfe_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);

   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         ring_mem[mem_cmd.wr_addr[IDX_W-1:0]] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= ring_mem[mem_cmd.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rbfe_ctrl.sv -----
// Sequencer of the frame extractor: ring pointers, frame search and the result register.
// Depends on rbfe_pkg; drives the access port of rbfe_ring.
`timescale 1ns / 1ps

module rbfe_ctrl #(
   parameter int RING_DEPTH = rbfe_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rbfe_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rbfe_pkg::rsp_type     rsp_data,
   input  rbfe_pkg::cfg_type     cfg,
   output rbfe_pkg::mem_cmd_type mem_cmd,
   input  logic [7:0]            mem_rdata
);
   import rbfe_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_W = (IDX_W + 1)'(RING_DEPTH);
   localparam logic [IDX_W-1:0] FULL_FILL = IDX_W'(RING_DEPTH - 1);
   localparam logic [IDX_W-1:0] MIN_HDR_FILL = IDX_W'(4);

   function automatic logic [IDX_W-1:0] add_wrap(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] sub_wrap(logic [IDX_W-1:0] a, logic [IDX_W-1:0] d);
      logic [IDX_W:0] s;
      s = {1'b0, a} + DEPTH_W - {1'b0, d};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[IDX_W-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic [IDX_W-1:0] wr_ff, wr_in;
   logic             ready_ff, ready_in;
   logic [7:0]       argc_ff, argc_in;
   logic [7:0]       param_ff, param_in;
   req_type          item_ff, item_in;
   logic             ok_ff, ok_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] fstart_ff, fstart_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       count_ff, count_in;
   logic [IDX_W-1:0] endpos_ff, endpos_in;
   logic [2:0]       step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0] fill;
   logic [7:0]       start_byte;
   logic [7:0]       end_byte;

   assign fill       = sub_wrap(wr_ff, rd_ff);
   assign start_byte = cfg.start_marker[8*step_ff +: 8];
   assign end_byte   = cfg.end_marker[8*step_ff +: 8];

   always_comb begin
      state_in     = state_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      ready_in     = ready_ff;
      argc_in      = argc_ff;
      param_in     = param_ff;
      item_in      = item_ff;
      ok_in        = ok_ff;
      ovf_in       = ovf_ff;
      fstart_in    = fstart_ff;
      len_in       = len_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      endpos_in    = endpos_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_cmd      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               ok_in    = 1'b0;
               ovf_in   = 1'b0;
               state_in = (req_data.cmd == CMD_POLL) ? ST_POLL : ST_STORE;
            end
         end
         ST_STORE: begin
            if (fill == FULL_FILL) begin
               ovf_in = 1'b1;
            end else begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = 8'(wr_ff);
               mem_cmd.wr_data = item_ff.rx_byte;
               wr_in           = add_wrap(wr_ff, IDX_W'(1));
            end
            state_in = ST_FINISH;
         end
         ST_POLL: begin
            if (rd_ff == wr_ff) begin
               state_in = ST_FINISH;
            end else begin
               ready_in = (9'(fill) <= 9'(cfg.busy_threshold));
               state_in = ST_SKIP_RD;
            end
         end
         ST_SKIP_RD: begin
            if (rd_ff == wr_ff) begin
               state_in = ST_FINISH;
            end else begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = 8'(rd_ff);
               state_in        = ST_SKIP_CHK;
            end
         end
         ST_SKIP_CHK: begin
            if (mem_rdata == cfg.start_marker[7:0]) begin
               if (fill > MIN_HDR_FILL) begin
                  step_in  = 3'd1;
                  state_in = ST_HDR_RD;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               rd_in    = add_wrap(rd_ff, IDX_W'(1));
               state_in = ST_SKIP_RD;
            end
         end
         ST_HDR_RD: begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = 8'(add_wrap(rd_ff, IDX_W'(step_ff)));
            state_in        = ST_HDR_CHK;
         end
         ST_HDR_CHK: begin
            if (step_ff == 3'd1 || step_ff == 3'd2) begin
               if (mem_rdata == start_byte) begin
                  step_in  = step_ff + 3'd1;
                  state_in = ST_HDR_RD;
               end else begin
                  rd_in    = add_wrap(rd_ff, IDX_W'(1));
                  state_in = ST_FINISH;
               end
            end else if (step_ff == 3'd3) begin
               cmd_in   = mem_rdata;
               step_in  = 3'd4;
               state_in = ST_HDR_RD;
            end else begin
               count_in = mem_rdata;
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (cmd_ff == code_byte(cfg.command_codes, CODE_DB) ||
                cmd_ff == code_byte(cfg.command_codes, CODE_DB_FAST)) begin
               len_in  = {count_ff[6:0], 1'b0} + LEN_DB_BASE;
               argc_in = count_ff;
            end else if (cmd_ff == code_byte(cfg.command_codes, CODE_RX_DB)) begin
               len_in = LEN_RX_DB;
            end else if (cmd_ff == code_byte(cfg.command_codes, CODE_SERIAL)) begin
               len_in = LEN_SERIAL;
            end else if (cmd_ff == code_byte(cfg.command_codes, CODE_COUNTER)) begin
               len_in = LEN_COUNTER;
            end else if (cmd_ff == code_byte(cfg.command_codes, CODE_MONITOR)) begin
               len_in   = LEN_MONITOR;
               param_in = count_ff;
            end else begin
               len_in = LEN_OTHER;
            end
            state_in = ST_END_SET;
         end
         ST_END_SET: begin
            if (9'(fill) >= 9'(len_ff)) begin
               endpos_in = add_wrap(rd_ff, IDX_W'(len_ff));
               step_in   = 3'd0;
               state_in  = ST_END_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_END_RD: begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = 8'(sub_wrap(endpos_ff, IDX_W'(3'd3 - step_ff)));
            state_in        = ST_END_CHK;
         end
         ST_END_CHK: begin
            if (mem_rdata != end_byte) begin
               rd_in    = add_wrap(rd_ff, IDX_W'(1));
               state_in = ST_FINISH;
            end else if (step_ff == 3'd2) begin
               ok_in     = 1'b1;
               fstart_in = rd_ff;
               rd_in     = endpos_ff;
               state_in  = ST_FINISH;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_END_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.ready_res     = ready_ff;
               rsp_data_in.frame_ok      = ok_ff;
               rsp_data_in.frame_start   = ok_ff ? 8'(fstart_ff) : 8'd0;
               rsp_data_in.frame_length  = ok_ff ? len_ff : 8'd0;
               rsp_data_in.frame_command = ok_ff ? cmd_ff : 8'd0;
               rsp_data_in.arg_count     = argc_ff;
               rsp_data_in.monitor_param = param_ff;
               rsp_data_in.overflow      = ovf_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ff        <= '0;
         wr_ff        <= '0;
         ready_ff     <= 1'b1;
         argc_ff      <= '0;
         param_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         ready_ff     <= ready_in;
         argc_ff      <= argc_in;
         param_ff     <= param_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ok_ff       <= ok_in;
      ovf_ff      <= ovf_in;
      fstart_ff   <= fstart_in;
      len_ff      <= len_in;
      cmd_ff      <= cmd_in;
      count_ff    <= count_in;
      endpos_ff   <= endpos_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |-> (state_ff == ST_STORE && fill != FULL_FILL))
      else $error("Ring written outside a store or into a full ring.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP_CHK || state_ff == ST_HDR_CHK || state_ff == ST_END_CHK)
      |-> $past(mem_cmd.rd_en))
      else $error("Read data checked without a read issued in the cycle before.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |=> $stable(rd_ff))
      else $error("A store moved the read index.");

   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rd_ff} < DEPTH_W) && ({1'b0, wr_ff} < DEPTH_W))
      else $error("Ring index beyond the ring depth.");

endmodule
